FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Defines the request and response payload structs and the operation codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W        = 16;
  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  // operation codes
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [PRIO_W-1:0] new_priority;
    logic        [DATA_W-1:0] new_data;
  } req_t;

  typedef struct packed {
    logic                      taken_valid;
    logic         [DATA_W-1:0] taken_data;
    logic                      head_valid;
    logic signed  [PRIO_W-1:0] head_priority;
    logic         [DATA_W-1:0] head_data;
    logic        [COUNT_W-1:0] entry_count;
    logic                      refused;
  } rsp_t;

endpackage

FILE: src/stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted-list priority queue
// Holds up to DEPTH entries in ascending priority order, ties in arrival order.
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_ready / req): one operation per transfer,
//     kind selects enqueue of new_priority and new_data, or dequeue of the head
//   rsp channel (rsp_valid / rsp_ready / rsp): exactly one response per
//     request, carrying the removed entry, a peek at the head, the entry count
//     and a refusal flag for an enqueue into a full queue
//   response: the response is registered and appears in the cycle after the
//     request transfer
//   throughput: one operation per cycle while rsp_ready stays high; all slots
//     compare against the new priority in parallel and shift by one place at
//     once, so the compare-and-shift stage between the slot registers sets the rate
//   stall: the response register holds while rsp_ready is low; a new request
//     is taken in the same cycle the held response leaves, so with rsp_ready
//     held high the queue runs back to back
//   reset: rst (synchronous, active high) empties the queue and drops any
//     pending response; slot contents stay undefined until written and are
//     never looked at beyond the entry count
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // sorted slots, slot 0 is the head
  logic signed [PRIO_W-1:0] slot_priority      [DEPTH];
  logic        [DATA_W-1:0] slot_data          [DEPTH];
  logic signed [PRIO_W-1:0] slot_priority_next [DEPTH];
  logic        [DATA_W-1:0] slot_data_next     [DEPTH];
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;

  logic [DEPTH-1:0] stay;   // slot keeps its entry: held and not above new priority
  logic             fire;
  logic             do_enq;
  logic             do_deq;
  logic             full;
  logic             empty;
  rsp_t             rsp_next;

  // response register frees up when it is empty or being taken
  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign do_enq    = fire && (req.kind == KIND_ENQ) && !full;
  assign do_deq    = fire && (req.kind == KIND_DEQ) && !empty;

  // parallel compare: equal priorities stay ahead, so the new entry lands behind them
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stay[i] = (CW'(i) < count) && (slot_priority[i] <= req.new_priority);
    end
  end

  // insert or remove with a one-place shift across all slots
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_priority_next[i] = slot_priority[i];
      slot_data_next[i]     = slot_data[i];
      if (do_enq) begin
        if (stay[i]) begin
          slot_priority_next[i] = slot_priority[i];
          slot_data_next[i]     = slot_data[i];
        end else if (i == 0) begin
          slot_priority_next[i] = req.new_priority;
          slot_data_next[i]     = req.new_data;
        end else if (stay[(i == 0) ? 0 : i-1]) begin
          slot_priority_next[i] = req.new_priority;
          slot_data_next[i]     = req.new_data;
        end else begin
          slot_priority_next[i] = slot_priority[(i == 0) ? 0 : i-1];
          slot_data_next[i]     = slot_data[(i == 0) ? 0 : i-1];
        end
      end else if (do_deq && (i < DEPTH - 1)) begin
        slot_priority_next[i] = slot_priority[(i < DEPTH - 1) ? i+1 : i];
        slot_data_next[i]     = slot_data[(i < DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CW'(1);
    end else if (do_deq) begin
      count_next = count - CW'(1);
    end
  end

  // response built from the state after this operation
  always_comb begin
    rsp_next               = '0;
    rsp_next.taken_valid   = do_deq;
    rsp_next.taken_data    = do_deq ? slot_data[0] : '0;
    rsp_next.head_valid    = (count_next != '0);
    rsp_next.head_priority = (count_next != '0) ? slot_priority_next[0] : '0;
    rsp_next.head_data     = (count_next != '0) ? slot_data_next[0] : '0;
    rsp_next.entry_count   = COUNT_W'(count_next);
    rsp_next.refused       = fire && (req.kind == KIND_ENQ) && full;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_priority[i] <= slot_priority_next[i];
      slot_data[i]     <= slot_data_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above depth");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && $past(fire) |-> rsp.head_valid == (count != '0))
    else $error("head valid disagrees with entry count");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    fire && (req.kind == KIND_DEQ) && empty |=> !rsp.taken_valid && count == '0)
    else $error("dequeue from empty queue removed an entry");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    fire && (req.kind == KIND_ENQ) && full |=> rsp.refused && count == FULL_COUNT)
    else $error("enqueue into full queue not refused");

  for (genvar g = 0; g < DEPTH - 1; g++) begin : g_order
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      (CW'(g + 1) < count) |-> slot_priority[g] <= slot_priority[g+1])
      else $error("held slots out of priority order");
  end

endmodule

FILE: tb/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// Drives enqueue and dequeue requests with random bursts and gaps, stalls the
// response side on a pattern of its own, and compares every response field
// against a bench-kept sorted-list shadow of the queue, or a typed row's want.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_OPS = 1650;

  // one row of the directed table; typed rows carry a hand-written response
  typedef struct packed {
    req_t op;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // shadow of the queue contents, slot 0 is the head
  logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
  logic        [DATA_W-1:0] shadow_data [DEPTH];
  int                       shadow_count = 0;

  rsp_t     awaited_rsp [$];
  dir_row_t dir_rows [$];
  int       err_count = 0;
  int       burst_left = 0;

  stable_priority_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sorted insert behind equal priorities, or head removal; returns the
  // response the queue should give for this operation
  function automatic rsp_t apply_queue_op(input req_t r);
    rsp_t o;
    int   pos;
    o = '0;
    if (r.kind == KIND_ENQ) begin
      if (shadow_count == DEPTH) begin
        // full: entry dropped, contents untouched
        o.refused = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= r.new_priority) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_data[i] = shadow_data[i-1];
        end
        shadow_prio[pos] = r.new_priority;
        shadow_data[pos] = r.new_data;
        shadow_count++;
      end
    end else if (shadow_count > 0) begin
      o.taken_valid = 1'b1;
      o.taken_data  = shadow_data[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_prio[i-1] = shadow_prio[i];
        shadow_data[i-1] = shadow_data[i];
      end
      shadow_count--;
    end
    // peek fields read zero when empty
    if (shadow_count > 0) begin
      o.head_valid    = 1'b1;
      o.head_priority = shadow_prio[0];
      o.head_data     = shadow_data[0];
    end
    o.entry_count = COUNT_W'(shadow_count);
    return o;
  endfunction

  function automatic req_t enq_op(input logic signed [PRIO_W-1:0] p,
                                  input logic [DATA_W-1:0] d);
    req_t r;
    r.kind         = KIND_ENQ;
    r.new_priority = p;
    r.new_data     = d;
    return r;
  endfunction

  function automatic req_t deq_op(input logic signed [PRIO_W-1:0] p,
                                  input logic [DATA_W-1:0] d);
    req_t r;
    r.kind         = KIND_DEQ;
    r.new_priority = p;
    r.new_data     = d;
    return r;
  endfunction

  function automatic rsp_t rsp_of(input logic tv, input logic [DATA_W-1:0] td,
                                  input logic hv, input logic signed [PRIO_W-1:0] hp,
                                  input logic [DATA_W-1:0] hd,
                                  input logic [COUNT_W-1:0] cnt, input logic rf);
    rsp_t o;
    o.taken_valid   = tv;
    o.taken_data    = td;
    o.head_valid    = hv;
    o.head_priority = hp;
    o.head_data     = hd;
    o.entry_count   = cnt;
    o.refused       = rf;
    return o;
  endfunction

  function automatic dir_row_t row(input req_t op, input bit typed, input rsp_t want);
    dir_row_t d;
    d.op    = op;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  // offer one request, holding it until the transfer; the sender works in
  // bursts and drops valid only between bursts
  task automatic offer(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    // transfer happened at this edge: advance the shadow queue
    predicted = apply_queue_op(r);
    awaited_rsp.push_back(typed ? want : predicted);
    burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                       enq_pct;
    int                       pick;
    int                       drain_cycles;
    logic signed [PRIO_W-1:0] p;
    req_t                     r;

    // dequeue on an empty queue: nothing taken, all zero
    dir_rows.push_back(row(deq_op(16'sh1234, 32'hDEADBEEF), 1'b1,
                           rsp_of(1'b0, '0, 1'b0, '0, '0, 5'd0, 1'b0)));
    // priority and data extremes
    dir_rows.push_back(row(enq_op(16'sh7FFF, 32'hFFFFFFFF), 1'b1,
                           rsp_of(1'b0, '0, 1'b1, 16'sh7FFF, 32'hFFFFFFFF, 5'd1, 1'b0)));
    dir_rows.push_back(row(enq_op(16'sh8000, 32'h00000000), 1'b1,
                           rsp_of(1'b0, '0, 1'b1, 16'sh8000, 32'h00000000, 5'd2, 1'b0)));
    // equal priorities must leave in arrival order
    dir_rows.push_back(row(enq_op(16'sh0000, 32'hA0000001), 1'b0, '0));
    dir_rows.push_back(row(enq_op(16'sh0000, 32'hA0000002), 1'b0, '0));
    dir_rows.push_back(row(enq_op(16'sh0000, 32'hA0000003), 1'b0, '0));
    // either side of the sign boundary
    dir_rows.push_back(row(enq_op(16'shFFFF, 32'h5555AAAA), 1'b0, '0));
    dir_rows.push_back(row(enq_op(16'sh0001, 32'hAAAA5555), 1'b0, '0));
    // fill the remaining slots, mixed order
    for (int i = 0; i < DEPTH - 7; i++) begin
      dir_rows.push_back(row(enq_op(PRIO_W'((i % 2 ? 1 : -1) * (i * 1111 + 7)),
                                    32'hC0DE0000 + i), 1'b0, '0));
    end
    // enqueue into a full queue is refused and leaves the head alone
    dir_rows.push_back(row(enq_op(16'sh8000, 32'h0BAD0BAD), 1'b1,
                           rsp_of(1'b0, '0, 1'b1, 16'sh8000, 32'h00000000, 5'(DEPTH), 1'b1)));
    // drain a few, with junk in the unused fields
    for (int i = 0; i < 6; i++) begin
      dir_rows.push_back(row(deq_op(PRIO_W'($urandom), $urandom), 1'b0, '0));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);

    // random part: phases lean toward filling, draining or churning so that
    // full and empty states are both hit repeatedly
    enq_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        p = PRIO_W'($signed($urandom_range(0, 6)) - 3);  // dense ties
      end else if (pick < 8) begin
        p = PRIO_W'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0:       p = 16'sh8000;
          1:       p = 16'sh7FFF;
          2:       p = 16'shFFFF;
          default: p = 16'sh0000;
        endcase
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        r = enq_op(p, $urandom);
      end else begin
        r = deq_op(p, $urandom);
      end
      offer(r, 1'b0, '0);
    end

    req_valid <= 1'b0;
    drain_cycles = 0;
    while (awaited_rsp.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    // then keep the clock running to catch any stray response
    repeat (8) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, awaited_rsp.size());
      err_count += awaited_rsp.size();
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response side: changing stall patterns plus two long hold-offs during
  // which the sender keeps offering, so the response register backs up and
  // req_ready has to drop
  // ---------------------------------------------------------------------------
  initial begin : rsp_side
    int cyc;
    int hold_left;
    int mode;
    int mode_left;
    cyc       = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 300 || cyc == 3000) hold_left = 120;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          0:       rsp_ready <= 1'b1;                          // no stalls
          1:       rsp_ready <= ($urandom_range(0, 1) == 1);   // coin flip
          2:       rsp_ready <= ($urandom_range(0, 7) == 0);   // mostly stalled
          default: rsp_ready <= (cyc % 8) < 4;                 // alternating on and off runs
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        err_count++;
      end else begin
        want = awaited_rsp.pop_front();
        check_field("taken_valid",   64'(want.taken_valid),            64'(rsp.taken_valid));
        check_field("taken_data",    64'(want.taken_data),             64'(rsp.taken_data));
        check_field("head_valid",    64'(want.head_valid),             64'(rsp.head_valid));
        check_field("head_priority", 64'($unsigned(want.head_priority)),
                    64'($unsigned(rsp.head_priority)));
        check_field("head_data",     64'(want.head_data),              64'(rsp.head_data));
        check_field("entry_count",   64'(want.entry_count),            64'(rsp.entry_count));
        check_field("refused",       64'(want.refused),                64'(rsp.refused));
      end
    end
  end

endmodule
